/* design/btg_pkg.sv */
// ----------------------------------------------------------------------------
// btg_pkg
// shared constants and helpers of the bernoulli cell traffic generator
// ----------------------------------------------------------------------------
`default_nettype none

package btg_pkg;

    localparam int DEF_MAX_PRIORITIES = 8;
    localparam int DEF_MAX_OUTPUTS    = 64;

    localparam int GEN_W  = 48;
    localparam int PROB_W = 49;
    localparam int REM_W  = 56;

    localparam logic [PROB_W-1:0] ONE48   = 49'h1_0000_0000_0000;
    localparam logic [34:0]       LCG_MUL = 35'h5_DEEC_E66D;
    localparam logic [GEN_W-1:0]  LCG_ADD = 48'hB;

    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_LOAD_U = 2'd1;
    localparam logic [1:0] OP_LOAD_M = 2'd2;
    localparam logic [1:0] OP_RESEED = 2'd3;

    localparam logic [2:0] REG_TOTAL_UTIL  = 3'd0;
    localparam logic [2:0] REG_MCAST_FRAC  = 3'd1;
    localparam logic [2:0] REG_NUM_OUTPUTS = 3'd2;
    localparam logic [2:0] REG_PRIO_LEVELS = 3'd3;
    localparam logic [2:0] REG_SEED_MIX    = 3'd4;

    localparam logic [15:0] SEED_ARR0 = 16'h1234;
    localparam logic [15:0] SEED_ARR1 = 16'hde91;
    localparam logic [15:0] SEED_ARR2 = 16'h4184;
    localparam logic [15:0] SEED_PRT0 = 16'h3234;
    localparam logic [15:0] SEED_PRT1 = 16'h287d;
    localparam logic [15:0] SEED_PRT2 = 16'hbd39;
    localparam logic [15:0] SEED_CST0 = 16'ha561;
    localparam logic [15:0] SEED_CST1 = 16'ha123;
    localparam logic [15:0] SEED_CST2 = 16'ha736;

    function automatic logic [PROB_W-1:0] sat_one(input logic [PROB_W-1:0] v);
        return (v > ONE48) ? ONE48 : v;
    endfunction

    function automatic logic [GEN_W-1:0] seed_of(input logic [15:0] w0, input logic [15:0] w1,
                                                 input logic [15:0] w2, input logic [15:0] m);
        return {w2 ^ m, w1 ^ m, w0 ^ m};
    endfunction

endpackage

`default_nettype wire

/* design/btg_lcg.sv */
// ----------------------------------------------------------------------------
// btg_lcg
// rand48 step x' = a*x + c mod 2^48, one 16-bit slice of x per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module btg_lcg
    import btg_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [GEN_W-1:0] seed,
    output logic                  done,
    output logic [GEN_W-1:0]      result
);

    logic [GEN_W-1:0] x_reg;
    logic [GEN_W-1:0] acc_reg;
    logic [1:0]       cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [15:0]      slice;
    logic [50:0]      prod;
    logic [GEN_W-1:0] prod_sh;

    always_comb
    begin
        case (cnt_reg)
            2'd0:    slice = x_reg[15:0];
            2'd1:    slice = x_reg[31:16];
            default: slice = x_reg[47:32];
        endcase
        prod = 51'(LCG_MUL) * 51'(slice);
        case (cnt_reg)
            2'd0:    prod_sh = prod[47:0];
            2'd1:    prod_sh = {prod[31:0], 16'd0};
            default: prod_sh = {prod[15:0], 32'd0};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 2'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd2)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= seed;
            acc_reg <= LCG_ADD;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_reg + prod_sh;
        end
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule

`default_nettype wire

/* design/bernoulli_cell_traffic_generator.sv */
// ----------------------------------------------------------------------------
// bernoulli_cell_traffic_generator
// per-tick bernoulli cell source with priority walk and uniform unicast port
// ----------------------------------------------------------------------------
//  channel  | handshake               | payload
//  input    | in_valid / in_stall     | operation, share_index, share_value
//  output   | out_valid / out_stall   | cell_valid, is_multicast, cell_priority, dest_port
//  config   | apb psel/penable/pwrite | paddr (8*index), pwdata, prdata
//
//  a load or reseed goes straight to the done state; a tick draws one lcg step
//  per generator in use (arrival, then cast for a cell, then port for a
//  unicast cell), one share table read per walked level, and a 31-step
//  restoring modulo for the port
//  share tables reset to zero through per-entry valid bits, no clearing pass
//  a new request is taken while the previous result waits on out_stall; a
//  finished result then holds the sequencer until the output register frees
// ----------------------------------------------------------------------------
`default_nettype none

module bernoulli_cell_traffic_generator
    import btg_pkg::*;
#(
    parameter int MAX_PRIORITIES = DEF_MAX_PRIORITIES,
    parameter int MAX_OUTPUTS    = DEF_MAX_OUTPUTS
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [5:0]        paddr,
    input  wire logic [63:0]       pwdata,
    output logic      [63:0]       prdata,
    output logic                   pready,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [1:0]        operation,
    input  wire logic [2:0]        share_index,
    input  wire logic [PROB_W-1:0] share_value,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic                   cell_valid,
    output logic                   is_multicast,
    output logic [2:0]             cell_priority,
    output logic [5:0]             dest_port
);

    localparam int PW = (MAX_PRIORITIES > 1) ? $clog2(MAX_PRIORITIES) : 1;
    localparam int NW = $clog2(MAX_OUTPUTS + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ARR  = 3'd1;
    localparam logic [2:0] ST_CAST = 3'd2;
    localparam logic [2:0] ST_WALK = 3'd3;
    localparam logic [2:0] ST_PORT = 3'd4;
    localparam logic [2:0] ST_DIV  = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    // configuration registers
    logic [PROB_W-1:0] total_util_reg;
    logic [PROB_W-1:0] mcast_frac_reg;
    logic [6:0]        num_outputs_reg;
    logic [3:0]        prio_levels_reg;
    logic [15:0]       seed_mix_reg;
    logic              cfg_wr;

    // generators and share tables
    logic [GEN_W-1:0]  arrival_gen_reg;
    logic [GEN_W-1:0]  cast_gen_reg;
    logic [GEN_W-1:0]  port_gen_reg;
    logic [PROB_W-1:0] ushare_mem [MAX_PRIORITIES];
    logic [PROB_W-1:0] mshare_mem [MAX_PRIORITIES];
    logic [MAX_PRIORITIES-1:0] uvld_reg;
    logic [MAX_PRIORITIES-1:0] mvld_reg;
    logic [PROB_W-1:0] urd_reg;
    logic [PROB_W-1:0] mrd_reg;
    logic              uok_reg;
    logic              mok_reg;
    logic [PW-1:0]     raddr;

    // sequencer
    logic [2:0]        state_reg;
    logic [GEN_W-1:0]  draw_reg;
    logic              mc_reg;
    logic [PW-1:0]     p_reg;
    logic signed [REM_W-1:0] rem_reg;
    logic [30:0]       q_reg;
    logic [NW-1:0]     mod_reg;
    logic [NW-1:0]     n_reg;
    logic [4:0]        div_cnt_reg;
    logic              res_valid_reg;
    logic              res_mc_reg;
    logic [2:0]        res_prio_reg;
    logic [5:0]        res_port_reg;

    // output register
    logic              out_valid_reg;
    logic              out_cell_reg;
    logic              out_mc_reg;
    logic [2:0]        out_prio_reg;
    logic [5:0]        out_port_reg;

    logic              lcg_start;
    logic [GEN_W-1:0]  lcg_seed;
    logic              lcg_done;
    logic [GEN_W-1:0]  lcg_res;

    logic              accept;
    logic              out_free;
    logic [31:0]       idx_w;
    logic              idx_ok;
    logic [PROB_W-1:0] share_sat;
    logic [31:0]       lv_w;
    logic [PW-1:0]     lv_top;
    logic [PROB_W-1:0] share_rd;
    logic signed [REM_W-1:0] rem_new;
    logic              walk_hit;
    logic              walk_end;
    logic [31:0]       prio_w;
    logic [31:0]       n_w;
    logic [NW:0]       div_t;
    logic [NW-1:0]     mod_new;
    logic [31:0]       mod_w;
    logic [31:0]       wp_w;

    btg_lcg u_lcg (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (lcg_start),
        .seed   (lcg_seed),
        .done   (lcg_done),
        .result (lcg_res)
    );

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[5:3])
            REG_TOTAL_UTIL:  prdata = 64'(total_util_reg);
            REG_MCAST_FRAC:  prdata = 64'(mcast_frac_reg);
            REG_NUM_OUTPUTS: prdata = 64'(num_outputs_reg);
            REG_PRIO_LEVELS: prdata = 64'(prio_levels_reg);
            REG_SEED_MIX:    prdata = 64'(seed_mix_reg);
            default:         prdata = 64'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_util_reg  <= '0;
            mcast_frac_reg  <= '0;
            num_outputs_reg <= 7'd1;
            prio_levels_reg <= 4'd1;
            seed_mix_reg    <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[5:3])
                REG_TOTAL_UTIL:  total_util_reg  <= sat_one(pwdata[PROB_W-1:0]);
                REG_MCAST_FRAC:  mcast_frac_reg  <= sat_one(pwdata[PROB_W-1:0]);
                REG_NUM_OUTPUTS: num_outputs_reg <= pwdata[6:0];
                REG_PRIO_LEVELS: prio_levels_reg <= pwdata[3:0];
                REG_SEED_MIX:    seed_mix_reg    <= pwdata[15:0];
                default:         ;
            endcase
        end
    end

    // ---------------- request side ----------------
    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign idx_w     = 32'(share_index);
    assign idx_ok    = (idx_w < 32'(MAX_PRIORITIES));
    assign share_sat = sat_one(share_value);

    // levels in use, clamped to the table depth
    assign lv_w   = (32'(prio_levels_reg) > 32'(MAX_PRIORITIES)) ? 32'(MAX_PRIORITIES)
                                                                 : 32'(prio_levels_reg);
    assign lv_top = PW'(lv_w - 32'd1);

    assign share_rd = mc_reg ? (mok_reg ? mrd_reg : '0) : (uok_reg ? urd_reg : '0);
    assign rem_new  = rem_reg - REM_W'(share_rd);
    assign walk_hit = $signed(REM_W'(draw_reg)) > rem_new;
    assign walk_end = walk_hit || (p_reg == '0);
    assign prio_w   = walk_hit ? 32'(p_reg) : 32'd0;

    assign raddr = (state_reg == ST_WALK) ? (p_reg - PW'(1)) : lv_top;

    assign n_w = (num_outputs_reg == 7'd0) ? 32'd1 :
                 (32'(num_outputs_reg) > 32'(MAX_OUTPUTS)) ? 32'(MAX_OUTPUTS)
                                                           : 32'(num_outputs_reg);

    // restoring modulo, one dividend bit per cycle
    assign div_t   = {mod_reg, q_reg[30]};
    assign mod_new = (div_t >= {1'b0, n_reg}) ? NW'(div_t - {1'b0, n_reg}) : NW'(div_t);
    assign mod_w   = 32'(mod_new);
    assign wp_w    = 32'(lv_w == 32'd0);

    always_comb
    begin
        lcg_start = 1'b0;
        lcg_seed  = arrival_gen_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                lcg_start = accept && (operation == OP_TICK);
                lcg_seed  = arrival_gen_reg;
            end
            ST_ARR:
            begin
                lcg_start = lcg_done && ({1'b0, lcg_res} < total_util_reg);
                lcg_seed  = cast_gen_reg;
            end
            ST_CAST:
            begin
                lcg_start = lcg_done && ({1'b0, lcg_res} >= mcast_frac_reg) && (wp_w[0]);
                lcg_seed  = port_gen_reg;
            end
            ST_WALK:
            begin
                lcg_start = walk_end && !mc_reg;
                lcg_seed  = port_gen_reg;
            end
            default:
            begin
                lcg_start = 1'b0;
                lcg_seed  = arrival_gen_reg;
            end
        endcase
    end

    // share tables: written on load requests, read one level per cycle
    always_ff @(posedge clk)
    begin
        if (accept && idx_ok && (operation == OP_LOAD_U))
        begin
            ushare_mem[idx_w[PW-1:0]] <= share_sat;
        end
        if (accept && idx_ok && (operation == OP_LOAD_M))
        begin
            mshare_mem[idx_w[PW-1:0]] <= share_sat;
        end
        urd_reg <= ushare_mem[raddr];
        mrd_reg <= mshare_mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            uvld_reg <= '0;
            mvld_reg <= '0;
            uok_reg  <= 1'b0;
            mok_reg  <= 1'b0;
        end
        else
        begin
            if (accept && idx_ok && (operation == OP_LOAD_U))
            begin
                uvld_reg[idx_w[PW-1:0]] <= 1'b1;
            end
            if (accept && idx_ok && (operation == OP_LOAD_M))
            begin
                mvld_reg[idx_w[PW-1:0]] <= 1'b1;
            end
            uok_reg <= uvld_reg[raddr];
            mok_reg <= mvld_reg[raddr];
        end
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            arrival_gen_reg <= '0;
            cast_gen_reg    <= '0;
            port_gen_reg    <= '0;
            div_cnt_reg     <= '0;
            draw_reg        <= '0;
            mc_reg          <= 1'b0;
            p_reg           <= '0;
            rem_reg         <= '0;
            q_reg           <= '0;
            mod_reg         <= '0;
            n_reg           <= '0;
            res_valid_reg   <= 1'b0;
            res_mc_reg      <= 1'b0;
            res_prio_reg    <= 3'd0;
            res_port_reg    <= 6'd0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        res_valid_reg <= 1'b0;
                        res_mc_reg    <= 1'b0;
                        res_prio_reg  <= 3'd0;
                        res_port_reg  <= 6'd0;
                        if (operation == OP_TICK)
                        begin
                            state_reg <= ST_ARR;
                        end
                        else
                        begin
                            state_reg <= ST_DONE;
                        end
                        if (operation == OP_RESEED)
                        begin
                            arrival_gen_reg <= seed_of(SEED_ARR0, SEED_ARR1, SEED_ARR2,
                                                       seed_mix_reg);
                            port_gen_reg    <= seed_of(SEED_PRT0, SEED_PRT1, SEED_PRT2,
                                                       seed_mix_reg);
                            cast_gen_reg    <= seed_of(SEED_CST0, SEED_CST1, SEED_CST2,
                                                       seed_mix_reg);
                        end
                    end
                end
                ST_ARR:
                begin
                    if (lcg_done)
                    begin
                        arrival_gen_reg <= lcg_res;
                        draw_reg        <= lcg_res;
                        state_reg       <= lcg_start ? ST_CAST : ST_DONE;
                    end
                end
                ST_CAST:
                begin
                    if (lcg_done)
                    begin
                        cast_gen_reg  <= lcg_res;
                        mc_reg        <= ({1'b0, lcg_res} < mcast_frac_reg);
                        res_valid_reg <= 1'b1;
                        res_mc_reg    <= ({1'b0, lcg_res} < mcast_frac_reg);
                        p_reg         <= lv_top;
                        rem_reg       <= REM_W'(total_util_reg);
                        // zero levels in use: priority 0 without a walk
                        if (wp_w[0])
                        begin
                            state_reg <= lcg_start ? ST_PORT : ST_DONE;
                        end
                        else
                        begin
                            state_reg <= ST_WALK;
                        end
                    end
                end
                ST_WALK:
                begin
                    rem_reg <= rem_new;
                    p_reg   <= p_reg - PW'(1);
                    if (walk_end)
                    begin
                        res_prio_reg <= prio_w[2:0];
                        state_reg    <= mc_reg ? ST_DONE : ST_PORT;
                    end
                end
                ST_PORT:
                begin
                    if (lcg_done)
                    begin
                        port_gen_reg <= lcg_res;
                        q_reg        <= lcg_res[47:17];
                        mod_reg      <= '0;
                        n_reg        <= NW'(n_w);
                        div_cnt_reg  <= '0;
                        state_reg    <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    mod_reg     <= mod_new;
                    q_reg       <= {q_reg[29:0], 1'b0};
                    div_cnt_reg <= div_cnt_reg + 5'd1;
                    if (div_cnt_reg == 5'd30)
                    begin
                        res_port_reg <= mod_w[5:0];
                        div_cnt_reg  <= '0;
                        state_reg    <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == ST_DONE) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_DONE) && out_free)
        begin
            out_cell_reg <= res_valid_reg;
            out_mc_reg   <= res_mc_reg;
            out_prio_reg <= res_prio_reg;
            out_port_reg <= res_port_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign cell_valid    = out_cell_reg;
    assign is_multicast  = out_mc_reg;
    assign cell_priority = out_prio_reg;
    assign dest_port     = out_port_reg;

`ifndef NO_ASSERTIONS
    a_lcg_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        lcg_done |-> (state_reg == ST_ARR || state_reg == ST_CAST || state_reg == ST_PORT))
        else $error("lcg result arrived with no step waiting on it");

    a_no_cell_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !cell_valid) |-> (!is_multicast && cell_priority == 3'd0
                                        && dest_port == 6'd0))
        else $error("empty slot carries cell fields");

    a_mcast_no_port: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_multicast) |-> (cell_valid && dest_port == 6'd0))
        else $error("multicast cell with a destination port");

    a_div_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        (div_cnt_reg != 5'd0) |-> (state_reg == ST_DIV))
        else $error("modulo counter running outside the modulo step");
`endif

endmodule

`default_nettype wire
